// ===== rtl/multi_rate_tick_scheduler_defines.svh =====
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MULTI_RATE_TICK_SCHEDULER_DEFINES_SVH
`define MULTI_RATE_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MRTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ===== rtl/mrts_pkg.sv =====
// Shared types, constants and helpers of the multi-rate tick scheduler.
// Depends on nothing; imported by every scheduler module.
package mrts_pkg;

  // Base tick rate in ticks per second and the derived per-rate dividers.
  localparam int TICK_RATE = 1000;
  localparam int DIV_MS    = TICK_RATE / 1000;
  localparam int DIV_CS    = TICK_RATE / 100;
  localparam int DIV_DS    = TICK_RATE / 10;

  localparam int PHASE_W = $clog2(TICK_RATE);
  localparam int MS_W    = (DIV_MS > 1) ? $clog2(DIV_MS) : 1;
  localparam int CS_W    = (DIV_CS > 1) ? $clog2(DIV_CS) : 1;
  localparam int DS_W    = (DIV_DS > 1) ? $clog2(DIV_DS) : 1;

  // Rate bit positions in the flag and delay vectors.
  localparam int RATE_MS = 0;
  localparam int RATE_CS = 1;
  localparam int RATE_DS = 2;
  localparam int RATE_S  = 3;

  // Opcodes.
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_LOAD_MS   = 3'd1;
  localparam logic [2:0] OP_LOAD_CS   = 3'd2;
  localparam logic [2:0] OP_LOAD_DS   = 3'd3;
  localparam logic [2:0] OP_LOAD_S    = 3'd4;
  localparam logic [2:0] OP_LOAD_BEEP = 3'd5;
  localparam logic [2:0] OP_LOAD_BIP  = 3'd6;
  localparam logic [2:0] OP_CLEAR     = 3'd7;

  // Configuration register indexes and reset values.
  localparam logic [1:0] CFG_BEEP_LENGTH = 2'd0;
  localparam logic [1:0] CFG_BIP_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_BIP_GAP     = 2'd2;

  localparam logic [7:0] BEEP_LENGTH_RST = 8'd60;
  localparam logic [7:0] BIP_LENGTH_RST  = 8'd5;
  localparam logic [3:0] BIP_GAP_RST     = 4'd10;

  // One input word.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] value;
    logic [3:0]  flags_to_clear;
  } item_t;

  // Configuration register contents.
  typedef struct packed {
    logic [7:0] beep_length;
    logic [7:0] bip_length;
    logic [3:0] bip_gap;
  } cfg_t;

  // One result word.
  typedef struct packed {
    logic [3:0]  rate_flags;
    logic [3:0]  delays_done;
    logic        buzzer_on;
    logic        led_on;
    logic [31:0] elapsed_seconds;
    logic        sounds_pending;
  } res_t;

  // Load counts above 255 saturate.
  function automatic logic [7:0] sat8(input logic [31:0] v);
    sat8 = (|v[31:8]) ? 8'hFF : v[7:0];
  endfunction

endpackage

// ===== rtl/mrts_in_stage.sv =====
// Input register of the scheduler: captures one word and its valid bit.
// Depends on mrts_pkg.
module mrts_in_stage
  import mrts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  item_t in_item,
  input  logic  advance,
  output logic  valid,
  output item_t item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // Hold while a captured word cannot move on.
  assign in_stall  = valid_r && !advance;
  assign valid_nxt = in_stall ? 1'b1 : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload loads only on an accepted word.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

// ===== rtl/mrts_sched.sv =====
// Scheduler state and its single-pass update for one word.
// Depends on mrts_pkg.
module mrts_sched
  import mrts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [MS_W-1:0]    ms_r, ms_nxt;
  logic [CS_W-1:0]    cs_r, cs_nxt;
  logic [DS_W-1:0]    ds_r, ds_nxt;
  logic [3:0]         flags_r, flags_nxt;
  logic [31:0]        delay_r [4];
  logic [31:0]        delay_nxt [4];
  logic [7:0]         buzz_left_r, buzz_left_nxt;
  logic               buzz_level_r, buzz_level_nxt;
  logic [3:0]         gap_left_r, gap_left_nxt;
  logic [7:0]         bips_left_r, bips_left_nxt;
  logic [7:0]         beeps_left_r, beeps_left_nxt;
  logic [31:0]        seconds_r, seconds_nxt;
  logic [3:0]         hits;
  logic               wrap;
  logic [3:0]         done;

  // Next state for one word.
  always_comb begin
    phase_nxt      = phase_r;
    ms_nxt         = ms_r;
    cs_nxt         = cs_r;
    ds_nxt         = ds_r;
    flags_nxt      = flags_r;
    delay_nxt      = delay_r;
    buzz_left_nxt  = buzz_left_r;
    buzz_level_nxt = buzz_level_r;
    gap_left_nxt   = gap_left_r;
    bips_left_nxt  = bips_left_r;
    beeps_left_nxt = beeps_left_r;
    seconds_nxt    = seconds_r;
    hits           = 4'b0000;
    wrap           = 1'b0;
    if (fire) begin
      case (item.opcode)
        OP_TICK: begin
          // Phase and the sub-counters that track phase modulo each divider.
          wrap      = (phase_r == PHASE_W'(TICK_RATE - 1));
          phase_nxt = wrap ? '0 : PHASE_W'(phase_r + 1'b1);
          ms_nxt    = (wrap || ms_r == MS_W'(DIV_MS - 1)) ? '0 : MS_W'(ms_r + 1'b1);
          cs_nxt    = (wrap || cs_r == CS_W'(DIV_CS - 1)) ? '0 : CS_W'(cs_r + 1'b1);
          ds_nxt    = (wrap || ds_r == DS_W'(DIV_DS - 1)) ? '0 : DS_W'(ds_r + 1'b1);
          hits[RATE_MS] = (ms_nxt == '0);
          hits[RATE_CS] = (cs_nxt == '0);
          hits[RATE_DS] = (ds_nxt == '0);
          hits[RATE_S]  = (phase_nxt == '0);

          // Each boundary sets its flag and counts its delay down to zero.
          for (int i = 0; i < 4; i++) begin
            if (hits[i]) begin
              flags_nxt[i] = 1'b1;
              if (delay_r[i] != 32'd0) begin
                delay_nxt[i] = delay_r[i] - 32'd1;
              end
            end
          end

          // 100 Hz: buzzer countdown first, then bip pacing.
          if (hits[RATE_CS]) begin
            if (buzz_left_r != 8'd0) begin
              buzz_left_nxt = buzz_left_r - 8'd1;
            end else begin
              buzz_level_nxt = 1'b0;
            end
            if (bips_left_r != 8'd0) begin
              if (gap_left_r != 4'd0) begin
                gap_left_nxt = gap_left_r - 4'd1;
              end else begin
                gap_left_nxt   = cfg.bip_gap;
                bips_left_nxt  = bips_left_r - 8'd1;
                buzz_left_nxt  = cfg.bip_length;
                buzz_level_nxt = 1'b1;
              end
            end
          end

          // 1 Hz: a pending beep takes the buzzer after the 100 Hz work.
          if (hits[RATE_S]) begin
            if (beeps_left_r != 8'd0) begin
              beeps_left_nxt = beeps_left_r - 8'd1;
              buzz_left_nxt  = cfg.beep_length;
              buzz_level_nxt = 1'b1;
            end
            seconds_nxt = seconds_r + 32'd1;
          end
        end
        OP_LOAD_MS, OP_LOAD_CS, OP_LOAD_DS, OP_LOAD_S: begin
          delay_nxt[2'(item.opcode - OP_LOAD_MS)] = item.value;
        end
        OP_LOAD_BEEP: begin
          beeps_left_nxt = sat8(item.value);
        end
        OP_LOAD_BIP: begin
          bips_left_nxt = sat8(item.value);
        end
        default: begin
          flags_nxt = flags_r & ~item.flags_to_clear;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= '0;
      ms_r         <= '0;
      cs_r         <= '0;
      ds_r         <= '0;
      flags_r      <= '0;
      delay_r      <= '{default: '0};
      buzz_left_r  <= '0;
      buzz_level_r <= 1'b0;
      gap_left_r   <= '0;
      bips_left_r  <= '0;
      beeps_left_r <= '0;
      seconds_r    <= '0;
    end else begin
      phase_r      <= phase_nxt;
      ms_r         <= ms_nxt;
      cs_r         <= cs_nxt;
      ds_r         <= ds_nxt;
      flags_r      <= flags_nxt;
      delay_r      <= delay_nxt;
      buzz_left_r  <= buzz_left_nxt;
      buzz_level_r <= buzz_level_nxt;
      gap_left_r   <= gap_left_nxt;
      bips_left_r  <= bips_left_nxt;
      beeps_left_r <= beeps_left_nxt;
      seconds_r    <= seconds_nxt;
    end
  end

  // Result word from the updated state.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      done[i] = (delay_nxt[i] == 32'd0);
    end
  end

  assign res.rate_flags      = flags_nxt;
  assign res.delays_done     = done;
  assign res.buzzer_on       = buzz_level_nxt;
  assign res.led_on          = seconds_nxt[0];
  assign res.elapsed_seconds = seconds_nxt;
  assign res.sounds_pending  = (beeps_left_nxt != 8'd0) || (bips_left_nxt != 8'd0);

endmodule

// ===== rtl/multi_rate_tick_scheduler.sv =====
// Top level of the multi-rate tick scheduler: configuration registers,
// input stage, scheduler state and the result register.
// Depends on mrts_pkg, mrts_in_stage, mrts_sched and the defines header.
//
// Takes one word per clock (a base tick, a counter load or a flag clear)
// and returns one result word for each, in order. Each accepted word is
// held in the input register and passes through the scheduler update
// into the result register. The sustained rate is one word per cycle
// whenever the result side does not stall; a stall backs up through the
// result register and the input register, so in_stall rises once both hold
// a word. Configuration writes are taken in any cycle (cfg_ready is always
// high); an index beyond the register list is ignored.
`include "multi_rate_tick_scheduler_defines.svh"

module multi_rate_tick_scheduler
  import mrts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [31:0] in_value,
  input  logic [3:0]  in_flags_to_clear,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_rate_flags,
  output logic [3:0]  out_delays_done,
  output logic        out_buzzer_on,
  output logic        out_led_on,
  output logic [31:0] out_elapsed_seconds,
  output logic        out_sounds_pending,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  cfg_t  cfg_r;
  item_t in_item;
  item_t s1_item;
  logic  s1_valid;
  logic  advance;
  logic  fire;
  res_t  res;
  res_t  out_res_r;
  logic  out_valid_r;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.beep_length <= BEEP_LENGTH_RST;
      cfg_r.bip_length  <= BIP_LENGTH_RST;
      cfg_r.bip_gap     <= BIP_GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BEEP_LENGTH: cfg_r.beep_length <= cfg_data;
        CFG_BIP_LENGTH:  cfg_r.bip_length  <= cfg_data;
        CFG_BIP_GAP:     cfg_r.bip_gap     <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage.
  assign in_item.opcode         = in_opcode;
  assign in_item.value          = in_value;
  assign in_item.flags_to_clear = in_flags_to_clear;

  assign advance = !out_valid_r || !out_stall;
  assign fire    = s1_valid && advance;

  mrts_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  // Scheduler state update.
  mrts_sched u_sched (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_rate_flags      = out_res_r.rate_flags;
  assign out_delays_done     = out_res_r.delays_done;
  assign out_buzzer_on       = out_res_r.buzzer_on;
  assign out_led_on          = out_res_r.led_on;
  assign out_elapsed_seconds = out_res_r.elapsed_seconds;
  assign out_sounds_pending  = out_res_r.sounds_pending;

  // The input side stalls only when both stages hold a word and the output is stalled.
  `MRTS_ASSERT_SAME(a_stall_only_full, clk, rst_n, in_stall, s1_valid && out_valid_r && out_stall)
  // A word moved through the scheduler shows up as a result.
  `MRTS_ASSERT_NEXT(a_fire_gives_out, clk, rst_n, fire, out_valid)
  // With nothing in the input stage and the result drained, the output goes empty.
  `MRTS_ASSERT_NEXT(a_drain_empty, clk, rst_n, !s1_valid && advance, !out_valid)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for multi_rate_tick_scheduler: named tests drive words and
// register writes, and a built-in predictor checks every result word in order.
// Depends on mrts_pkg and the multi_rate_tick_scheduler RTL.
`timescale 1ns / 100ps

module tb_top;
  import mrts_pkg::*;

  // Register index past the end of the list; writes to it are dropped.
  localparam logic [1:0] CFG_SPARE = 2'd3;
  localparam int unsigned QUIET_LIMIT = 500;
  localparam int unsigned MAX_WAIT = 13;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = OP_TICK;
  logic [31:0] in_value = '0;
  logic [3:0]  in_flags_to_clear = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_rate_flags;
  logic [3:0]  out_delays_done;
  logic        out_buzzer_on;
  logic        out_led_on;
  logic [31:0] out_elapsed_seconds;
  logic        out_sounds_pending;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_BEEP_LENGTH;
  logic [7:0]  cfg_data = '0;

  multi_rate_tick_scheduler DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_value            (in_value),
    .in_flags_to_clear   (in_flags_to_clear),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_rate_flags      (out_rate_flags),
    .out_delays_done     (out_delays_done),
    .out_buzzer_on       (out_buzzer_on),
    .out_led_on          (out_led_on),
    .out_elapsed_seconds (out_elapsed_seconds),
    .out_sounds_pending  (out_sounds_pending),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #4 clk = ~clk;

  // Predicted scheduler state and register contents.
  cfg_t        sched_cfg;
  int unsigned tick_phase;
  logic [3:0]  rate_seen;
  logic [31:0] delay_left [4];
  logic [7:0]  buzz_count;
  logic        buzz_level;
  logic [3:0]  gap_count;
  logic [7:0]  bips_queued;
  logic [7:0]  beeps_queued;
  logic [31:0] seconds_count;

  res_t expected_status [$];

  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned bips_sounded = 0;
  int unsigned beeps_sounded = 0;
  int unsigned quiet_cycles = 0;
  int unsigned in_idle_mode = 0;
  int unsigned out_idle_mode = 0;

  // Idle draw: mode 0 never waits, mode 1 waits now and then, mode 2 always draws.
  function automatic int unsigned draw_wait(input int unsigned mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
      default: return $urandom_range(0, MAX_WAIT);
    endcase
  endfunction

  // Count values: mostly small so delays and sounds run out, sometimes huge.
  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return $urandom_range(0, 300);
      2: return $urandom;
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  function automatic logic [7:0] clamp_count(input logic [31:0] v);
    return (v > 32'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic int unsigned ticks_per(input int unsigned hz);
    int unsigned d;
    d = TICK_RATE / hz;
    return (d == 0) ? 1 : d;
  endfunction

  task automatic reset_model();
    sched_cfg = '{beep_length: BEEP_LENGTH_RST, bip_length: BIP_LENGTH_RST,
                  bip_gap: BIP_GAP_RST};
    tick_phase = 0;
    rate_seen = '0;
    foreach (delay_left[i]) delay_left[i] = '0;
    buzz_count = '0;
    buzz_level = 1'b0;
    gap_count = '0;
    bips_queued = '0;
    beeps_queued = '0;
    seconds_count = '0;
  endtask

  task automatic hit_rate(input int r);
    rate_seen[r] = 1'b1;
    if (delay_left[r] != 0) delay_left[r] = delay_left[r] - 1;
  endtask

  // One base tick: advance the phase and run the work of every boundary it lands on.
  task automatic advance_tick();
    tick_phase++;
    if (tick_phase >= TICK_RATE) tick_phase = 0;
    if (tick_phase % ticks_per(1000) == 0) hit_rate(RATE_MS);
    if (tick_phase % ticks_per(100) == 0) begin
      hit_rate(RATE_CS);
      // The running countdown is handled before a new bip may start.
      if (buzz_count != 0) buzz_count--;
      else buzz_level = 1'b0;
      if (bips_queued != 0) begin
        if (gap_count != 0) begin
          gap_count--;
        end else begin
          gap_count = sched_cfg.bip_gap;
          bips_queued--;
          buzz_count = sched_cfg.bip_length;
          buzz_level = 1'b1;
          bips_sounded++;
        end
      end
    end
    if (tick_phase % ticks_per(10) == 0) hit_rate(RATE_DS);
    if (tick_phase % ticks_per(1) == 0) begin
      hit_rate(RATE_S);
      if (beeps_queued != 0) begin
        beeps_queued--;
        buzz_count = sched_cfg.beep_length;
        buzz_level = 1'b1;
        beeps_sounded++;
      end
      seconds_count++;
    end
  endtask

  // Apply one accepted word and queue the status word it must produce.
  task automatic predict_status(input logic [2:0] op, input logic [31:0] val,
                                input logic [3:0] mask);
    res_t r;
    case (op)
      OP_TICK: advance_tick();
      OP_LOAD_MS, OP_LOAD_CS, OP_LOAD_DS, OP_LOAD_S: delay_left[op - OP_LOAD_MS] = val;
      OP_LOAD_BEEP: beeps_queued = clamp_count(val);
      OP_LOAD_BIP: bips_queued = clamp_count(val);
      OP_CLEAR: rate_seen = rate_seen & ~mask;
      default: ;
    endcase
    r.rate_flags = rate_seen;
    foreach (delay_left[i]) r.delays_done[i] = (delay_left[i] == 0);
    r.buzzer_on = buzz_level;
    r.led_on = seconds_count[0];
    r.elapsed_seconds = seconds_count;
    r.sounds_pending = (beeps_queued != 0) || (bips_queued != 0);
    expected_status.push_back(r);
  endtask

  // Send one word; valid stays high afterwards so back-to-back words need no gap.
  task automatic send_word(input logic [2:0] op, input logic [31:0] val,
                           input logic [3:0] mask);
    int unsigned hold;
    if (words_sent % 64 == 0) begin
      in_idle_mode = $urandom_range(0, 2);
      out_idle_mode = $urandom_range(0, 2);
    end
    hold = draw_wait(in_idle_mode);
    if (hold != 0) begin
      in_valid <= 1'b0;
      repeat (hold) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_value <= val;
    in_flags_to_clear <= mask;
    do @(posedge clk); while (in_stall);
    predict_status(op, val, mask);
    words_sent++;
  endtask

  // Mostly ticks, with loads of every kind and flag clears mixed in.
  task automatic send_random_word();
    int unsigned roll;
    logic [2:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 70) op = OP_TICK;
    else if (roll < 90) op = 3'($urandom_range(OP_LOAD_MS, OP_LOAD_BIP));
    else op = OP_CLEAR;
    send_word(op, pick_count(), 4'($urandom_range(0, 15)));
  endtask

  // Lower valid, wait for every outstanding result, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write every register, the spare index too, holding valid across the burst.
  task automatic write_config(input logic [7:0] beep_len, input logic [7:0] bip_len,
                              input logic [7:0] gap_len, input logic [7:0] spare);
    logic [7:0] data [4];
    logic [1:0] regs [4];
    data = '{beep_len, bip_len, gap_len, spare};
    regs = '{CFG_BEEP_LENGTH, CFG_BIP_LENGTH, CFG_BIP_GAP, CFG_SPARE};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= data[i];
      do @(posedge clk); while (!cfg_ready);
      case (regs[i])
        CFG_BEEP_LENGTH: sched_cfg.beep_length = data[i];
        CFG_BIP_LENGTH: sched_cfg.bip_length = data[i];
        CFG_BIP_GAP: sched_cfg.bip_gap = data[i][3:0];
        default: ;
      endcase
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  // A stream of ticks with random ignored fields and a share of random words.
  task automatic run_ticks(input int unsigned count, input int unsigned noise_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < noise_pct) send_random_word();
      else send_word(OP_TICK, $urandom, 4'($urandom_range(0, 15)));
    end
  endtask

  // Queue beeps and bips, load the ms and s delays, then run the given number of base ticks.
  task automatic sound_run(input logic [31:0] beeps, input logic [31:0] bips,
                           input int unsigned ticks);
    send_word(OP_LOAD_BEEP, beeps, 4'($urandom_range(0, 15)));
    send_word(OP_LOAD_BIP, bips, 4'($urandom_range(0, 15)));
    send_word(OP_LOAD_MS, $urandom_range(1, 50), 4'h0);
    send_word(OP_LOAD_S, $urandom_range(1, 2), 4'h0);
    run_ticks(ticks, 3);
  endtask

  // Every opcode, ignored fields set, value extremes and saturating counts.
  task automatic test_directed_words();
    send_word(OP_TICK, 32'hFFFF_FFFF, 4'hF);
    send_word(OP_CLEAR, 32'hFFFF_FFFF, 4'h0);
    send_word(OP_CLEAR, 32'h0000_0000, 4'b0101);
    send_word(OP_LOAD_MS, 32'hFFFF_FFFF, 4'hF);
    send_word(OP_LOAD_CS, 32'h5555_5555, 4'h0);
    send_word(OP_LOAD_DS, 32'hAAAA_AAAA, 4'h0);
    send_word(OP_LOAD_S, 32'd1, 4'h0);
    send_word(OP_LOAD_MS, 32'd2, 4'h0);
    send_word(OP_LOAD_BEEP, 32'd256, 4'h0);
    send_word(OP_LOAD_BEEP, 32'hFFFF_FFFF, 4'h0);
    send_word(OP_LOAD_BEEP, 32'd0, 4'h0);
    send_word(OP_LOAD_BIP, 32'd255, 4'h0);
    send_word(OP_LOAD_BIP, 32'h8000_0000, 4'h0);
    send_word(OP_LOAD_BIP, 32'd1, 4'h0);
    // Nine more ticks reach the first 100 Hz boundary, where the bip starts.
    repeat (9) send_word(OP_TICK, 32'h0, 4'h0);
    send_word(OP_CLEAR, 32'h0, 4'b1010);
  endtask

  // Reset register values: beeps and bips queued, bips paced at 100 Hz.
  task automatic test_reset_config_sounds();
    settle();
    sound_run(32'd2, 32'd3, 130);
  endtask

  // Zero lengths and zero gap: the buzzer drops at the next 100 Hz boundary.
  task automatic test_zero_lengths();
    settle();
    write_config(8'd0, 8'd0, 8'd0, 8'($urandom));
    sound_run(32'd2, 32'd4, 130);
  endtask

  // Longest lengths; the gap write carries high bits that must be dropped.
  task automatic test_max_lengths();
    settle();
    write_config(8'hFF, 8'hFF, 8'hFF, 8'($urandom));
    sound_run(32'd300, 32'd2, 130);
  endtask

  // Random words in three rounds, each under fresh random register values.
  task automatic test_random_words();
    for (int round = 0; round < 3; round++) begin
      settle();
      write_config(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom));
      repeat (60) send_random_word();
    end
  endtask

  // Result side: draw a stall length for every word, then take the word.
  initial begin : result_sink
    int unsigned hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = draw_wait(out_idle_mode);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      if (errors < 40)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_status.size() == 0) begin
        errors++;
        $display("%0t: result word arrived with nothing expected", $time);
      end else begin
        want = expected_status.pop_front();
        check_field("rate_flags", 32'(want.rate_flags), 32'(out_rate_flags));
        check_field("delays_done", 32'(want.delays_done), 32'(out_delays_done));
        check_field("buzzer_on", 32'(want.buzzer_on), 32'(out_buzzer_on));
        check_field("led_on", 32'(want.led_on), 32'(out_led_on));
        check_field("elapsed_seconds", want.elapsed_seconds, out_elapsed_seconds);
        check_field("sounds_pending", 32'(want.sounds_pending), 32'(out_sounds_pending));
        results_checked++;
      end
    end
  end

  // Watchdog: any handshake restarts the count of quiet cycles.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_words();
    test_reset_config_sounds();
    test_zero_lengths();
    test_max_lengths();
    test_random_words();
    settle();
    repeat (8) @(posedge clk);
    errors += expected_status.size();
    $display("Checked %0d result words from %0d input words, %0d register writes.",
             results_checked, words_sent, cfg_writes);
    $display("Predicted %0d bips and %0d beeps over %0d elapsed seconds.",
             bips_sounded, beeps_sounded, seconds_count);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== multi_rate_tick_scheduler.f =====
+incdir+rtl
rtl/mrts_pkg.sv
rtl/mrts_in_stage.sv
rtl/mrts_sched.sv
rtl/multi_rate_tick_scheduler.sv
tb/tb_top.sv
